// ===== hdl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, codes and default sizes for the integer matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

  // Item kind codes
  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam int IDX_W     = 3;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 36;
  localparam int MAX_DIM   = 8;
  // Wide enough to hold row * dim + column for any dims up to MAX_DIM
  localparam int LIN_W     = 7;

  localparam int DEF_ROWS_LEFT  = 3;
  localparam int DEF_INNER_DIM  = 3;
  localparam int DEF_COLS_RIGHT = 2;

endpackage

`default_nettype wire

// ===== hdl/integer_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Loads signed matrices A and B element by element, then on a start item
// streams C = A * B in row-major order with exact 36-bit sums.
// ----------------------------------------------------------------------------
// Load items (A or B element) are taken one per cycle while idle. A start item
// runs C = A * B on one shared 16x16 multiplier and 36-bit accumulator; each
// inner step passes through memory read, multiply and accumulate, and a start
// item occupies the block until its last result enters the output register,
// longer while the result side stalls. The input is not ready during
// a run. Results leave through an output register, so the last result may
// still wait there while the next item is accepted. Every entry of both
// matrices must be loaded before a start item; loads with an index outside
// the matrix and items of unused kind are dropped.
`default_nettype none

module integer_matrix_multiply_core
  import imm_pkg::*;
#(
  parameter int ROWS_LEFT  = DEF_ROWS_LEFT,
  parameter int INNER_DIM  = DEF_INNER_DIM,
  parameter int COLS_RIGHT = DEF_COLS_RIGHT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic [1:0]               in_kind,
  input  wire logic [IDX_W-1:0]         in_row,
  input  wire logic [IDX_W-1:0]         in_column,
  input  wire logic signed [ELEM_W-1:0] in_element,

  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [IDX_W-1:0]         out_row,
  output      logic [IDX_W-1:0]         out_column,
  output      logic signed [SUM_W-1:0]  out_product_sum,
  output      logic                     out_last
);

  localparam int LEFT_DEPTH  = ROWS_LEFT * INNER_DIM;
  localparam int RIGHT_DEPTH = INNER_DIM * COLS_RIGHT;
  localparam int LEFT_AW     = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int RIGHT_AW    = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          i_r, i_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic [IDX_W-1:0]          k_r, k_nxt;
  logic signed [SUM_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_row_r, out_row_nxt;
  logic [IDX_W-1:0]          out_col_r, out_col_nxt;
  logic signed [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic                      out_last_r, out_last_nxt;

  logic signed [ELEM_W-1:0]  left_mem  [LEFT_DEPTH];
  logic signed [ELEM_W-1:0]  right_mem [RIGHT_DEPTH];
  logic signed [ELEM_W-1:0]  a_rd_r, b_rd_r;

  logic                      in_acc;
  logic [LIN_W-1:0]          wa_lin, wb_lin, ra_lin, rb_lin;
  logic                      wa_ok, wb_ok;
  logic                      last_i, last_j, last_k, out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Linear addresses, row-major
  assign wa_lin = LIN_W'(in_row) * LIN_W'(INNER_DIM) + LIN_W'(in_column);
  assign wb_lin = LIN_W'(in_row) * LIN_W'(COLS_RIGHT) + LIN_W'(in_column);
  assign ra_lin = LIN_W'(i_r) * LIN_W'(INNER_DIM) + LIN_W'(k_r);
  assign rb_lin = LIN_W'(k_r) * LIN_W'(COLS_RIGHT) + LIN_W'(j_r);

  assign wa_ok = ({1'b0, in_row} < (IDX_W+1)'(ROWS_LEFT)) &&
                 ({1'b0, in_column} < (IDX_W+1)'(INNER_DIM));
  assign wb_ok = ({1'b0, in_row} < (IDX_W+1)'(INNER_DIM)) &&
                 ({1'b0, in_column} < (IDX_W+1)'(COLS_RIGHT));

  // Matrix stores: written from load items, read under the sequencer
  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == KIND_LOAD_A) && wa_ok) begin
      left_mem[LEFT_AW'(wa_lin)] <= in_element;
    end
    a_rd_r <= left_mem[LEFT_AW'(ra_lin)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == KIND_LOAD_B) && wb_ok) begin
      right_mem[RIGHT_AW'(wb_lin)] <= in_element;
    end
    b_rd_r <= right_mem[RIGHT_AW'(rb_lin)];
  end

  // Shared multiplier
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(a_rd_r) * PROD_W'(b_rd_r);
    end
  end

  assign last_i   = (i_r == IDX_W'(ROWS_LEFT - 1));
  assign last_j   = (j_r == IDX_W'(COLS_RIGHT - 1));
  assign last_k   = (k_r == IDX_W'(INNER_DIM - 1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_START)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        acc_nxt = acc_r + SUM_W'(prod_r);
        if (last_k) begin
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = i_r;
          out_col_nxt   = j_r;
          out_sum_nxt   = acc_r;
          out_last_nxt  = last_i && last_j;
          acc_nxt       = '0;
          k_nxt         = '0;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
          state_nxt = (last_i && last_j) ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_column      = out_col_r;
  assign out_product_sum = out_sum_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire
